// ----- sv/bchr_pkg.sv -----
// ----------------------------------------------------------------------------
// bchr_pkg
// shared widths, codes and state types of the center-of-mass restraint block
// ----------------------------------------------------------------------------
package bchr_pkg;

  localparam int unsigned POS_W     = 32;  // signed fixed-point coordinate
  localparam int unsigned SUM_W     = 48;  // wrapping coordinate sum
  localparam int unsigned BOX_W     = 31;  // box length
  localparam int unsigned K_W       = 32;  // spring constant
  localparam int unsigned BLK_W     = 8;   // block index
  localparam int unsigned ACT_W     = 4;   // active block register
  localparam int unsigned OUT_OFF_W = 3;   // block offset result field
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned DIV_NUM_W = 52;  // shared divider dividend
  localparam int unsigned DIV_DEN_W = 33;  // shared divider divisor
  localparam int unsigned D_W       = 52;  // signed displacement
  localparam int unsigned MUL_W     = D_W + K_W;  // serial product
  localparam int unsigned IN_DAT_W  = 104;
  localparam int unsigned OUT_DAT_W = 104;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BLOCK = 3'd0,
    CFG_ACTIVE      = 3'd1,
    CFG_SPRING      = 3'd2,
    CFG_BOX_X       = 3'd3,
    CFG_BOX_Y       = 3'd4,
    CFG_BOX_Z       = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD_MIN = 1'b0,
    OP_BEAD     = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LOAD,
    B_DIV1,
    B_DIFF,
    B_DIV2,
    B_MUL,
    B_SAT,
    B_OUT,
    B_CLEAR
  } back_state_e;

endpackage

// ----- sv/block_com_harmonic_restraint.sv -----
// ----------------------------------------------------------------------------
// block_com_harmonic_restraint
// center-of-mass harmonic restraint over a window of blocks
// ----------------------------------------------------------------------------
// input stream: tuser = op (load minimum / bead), tlast = last bead of frame,
//   tdata = block index, x, y, z; one request is taken per cycle while beads
//   of a frame stream in, summed per block into flip-flop accumulators
// output stream: one request per restrained block in offset order after the
//   last bead; tuser flags an empty block, tlast marks the final block
// sequence: per axis, on one shared divider, a load step, the mean divide,
//   a compare step, the minimum-image divide, a serial multiply over the
//   bits of k and a saturate step; a block with beads runs this for all
//   three axes before its output step, an empty block goes from load
//   straight to output; a box length of zero skips the second divide for
//   that axis
// throughput: 1 bead per cycle; after a last bead input is held off until
//   every block result of that frame has been handed to the output register
//   and the sums have cleared
// reset: configuration returns to its reset values, minima, sums and counts
//   clear at once
// stall: the output register holds its request while tready is low and the
//   back end waits before writing the next one
// configuration: a plain write port that does not check state; the user must write only while the block is idle
// ----------------------------------------------------------------------------
module block_com_harmonic_restraint
  import bchr_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 8,
  parameter int unsigned MAX_BEADS  = 65536,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DAT_W-1:0]  s_axis_tdata,   // block_index, pos_x, pos_y, pos_z
  input  logic                 s_axis_tuser,   // op
  input  logic                 s_axis_tlast,   // is_last
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_DAT_W-1:0] m_axis_tdata,   // block_offset, force_x, force_y, force_z, pad
  output logic                 m_axis_tuser,   // empty_block
  output logic                 m_axis_tlast    // last
);

  localparam int unsigned OFF_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned NACT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_BEADS + 1);

  // configuration registers
  logic [BLK_W-1:0] start_q;
  logic [ACT_W-1:0] active_q;
  logic [K_W-1:0]   k_q;
  logic [BOX_W-1:0] box_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      active_q <= ACT_W'(1);
      k_q      <= '0;
      for (int a = 0; a < 3; a++) begin
        box_q[a] <= BOX_W'(32'h0001_0000);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_BLOCK: start_q  <= cfg_data_i[BLK_W-1:0];
        CFG_ACTIVE:      active_q <= cfg_data_i[ACT_W-1:0];
        CFG_SPRING:      k_q      <= cfg_data_i[K_W-1:0];
        CFG_BOX_X:       box_q[0] <= cfg_data_i[BOX_W-1:0];
        CFG_BOX_Y:       box_q[1] <= cfg_data_i[BOX_W-1:0];
        CFG_BOX_Z:       box_q[2] <= cfg_data_i[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  // window width, clipped to the storage depth
  logic [NACT_W-1:0] nact;
  assign nact = ({3'b0, active_q} > 7'(MAX_BLOCKS)) ? NACT_W'(MAX_BLOCKS)
                                                    : NACT_W'(active_q);

  // unpack input payload
  logic signed [POS_W-1:0] pos [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos[a] = s_axis_tdata[BLK_W + a*POS_W +: POS_W];
    end
  end

  logic                    push, full, pop, tok_valid, clr;
  logic [NACT_W-1:0]       tok_nact;
  logic [OFF_W-1:0]        rd_off;
  logic [CNT_W-1:0]        rd_cnt;
  logic signed [SUM_W-1:0] rd_sum [3];
  logic signed [POS_W-1:0] rd_min [3];

  bchr_front #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_BEADS  (MAX_BEADS),
    .OFF_W      (OFF_W),
    .NACT_W     (NACT_W),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .op_i     (s_axis_tuser),
    .blk_i    (s_axis_tdata[BLK_W-1:0]),
    .pos_i    (pos),
    .last_i   (s_axis_tlast),
    .start_i  (start_q),
    .nact_i   (nact),
    .push_o   (push),
    .full_i   (full),
    .clr_i    (clr),
    .rd_off_i (rd_off),
    .rd_cnt_o (rd_cnt),
    .rd_sum_o (rd_sum),
    .rd_min_o (rd_min)
  );

  // frame-end requests, tagged with the window width
  bchr_fifo #(
    .WIDTH (NACT_W),
    .DEPTH (2)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (nact),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (tok_valid),
    .pop_data_o  (tok_nact)
  );

  logic [OUT_OFF_W-1:0]    res_off;
  logic signed [POS_W-1:0] res_frc [3];

  bchr_back #(
    .OFF_W     (OFF_W),
    .NACT_W    (NACT_W),
    .CNT_W     (CNT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_nact_i  (tok_nact),
    .tok_pop_o   (pop),
    .rd_off_o    (rd_off),
    .rd_cnt_i    (rd_cnt),
    .rd_sum_i    (rd_sum),
    .rd_min_i    (rd_min),
    .k_i         (k_q),
    .box_i       (box_q),
    .clr_o       (clr),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .off_o       (res_off),
    .force_o     (res_frc),
    .empty_o     (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  // pack result payload, zero pad to whole bytes
  assign m_axis_tdata = {
    (OUT_DAT_W - OUT_OFF_W - 3*POS_W)'(0),
    res_frc[2], res_frc[1], res_frc[0], res_off
  };

endmodule

// ----- sv/bchr_div.sv -----
// ----------------------------------------------------------------------------
// bchr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bchr_div
  import bchr_pkg::*;
#(
  parameter int unsigned NUM_W = 52,
  parameter int unsigned DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [CW-1:0]    cnt_q;
  logic             run_q, done_q;
  logic [DEN_W:0]   shift, diff;
  logic             ge;

  always_comb begin
    shift = {rem_q, quo_q[NUM_W-1]};
    diff  = shift - {1'b0, den_q};
    ge    = shift >= {1'b0, den_q};
    rem_d = ge ? diff[DEN_W-1:0] : shift[DEN_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NUM_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/bchr_fifo.sv -----
// ----------------------------------------------------------------------------
// bchr_fifo
// short queue carrying frame-end requests from front to back
// ----------------------------------------------------------------------------
module bchr_fifo
  import bchr_pkg::*;
#(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    num_q;
  logic             do_push, do_pop;

  assign full_o     = num_q == NW'(DEPTH);
  assign valid_o    = num_q != '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      num_q <= num_q + NW'(do_push) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/bchr_front.sv -----
// ----------------------------------------------------------------------------
// bchr_front
// accepts requests, classifies them, keeps minima, sums and bead counts
// ----------------------------------------------------------------------------
module bchr_front
  import bchr_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 8,
  parameter int unsigned MAX_BEADS  = 65536,
  parameter int unsigned OFF_W      = 3,
  parameter int unsigned NACT_W     = 4,
  parameter int unsigned CNT_W      = 17
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic                    op_i,
  input  logic [BLK_W-1:0]        blk_i,
  input  logic signed [POS_W-1:0] pos_i [3],
  input  logic                    last_i,
  input  logic [BLK_W-1:0]        start_i,
  input  logic [NACT_W-1:0]       nact_i,
  output logic                    push_o,
  input  logic                    full_i,
  input  logic                    clr_i,
  input  logic [OFF_W-1:0]        rd_off_i,
  output logic [CNT_W-1:0]        rd_cnt_o,
  output logic signed [SUM_W-1:0] rd_sum_o [3],
  output logic signed [POS_W-1:0] rd_min_o [3]
);

  logic signed [SUM_W-1:0] sum_q [MAX_BLOCKS][3];
  logic signed [POS_W-1:0] min_q [MAX_BLOCKS][3];
  logic [CNT_W-1:0]        cnt_q [MAX_BLOCKS];
  logic                    busy_q;

  logic             accept, bead, load, in_win, add_ok, clear_all;
  logic [BLK_W-1:0] diff;
  logic [OFF_W-1:0] idx;

  assign ready_o = !busy_q && !full_i;
  assign accept  = valid_i && ready_o;
  assign diff    = blk_i - start_i;
  assign in_win  = (blk_i >= start_i) && ({1'b0, diff} < (BLK_W + 1)'(nact_i));
  assign bead    = accept && (op_i == OP_BEAD);
  assign load    = accept && (op_i == OP_LOAD_MIN)
                   && ((BLK_W + 1)'(blk_i) < (BLK_W + 1)'(MAX_BLOCKS));
  // back side owns the read index while a frame is being finished
  assign idx     = busy_q ? rd_off_i : diff[OFF_W-1:0];
  assign add_ok  = bead && in_win && (cnt_q[idx] < CNT_W'(MAX_BEADS));
  assign push_o  = bead && last_i && (nact_i != '0);
  // an empty window still ends the frame
  assign clear_all = clr_i || (bead && last_i && (nact_i == '0));

  assign rd_cnt_o = cnt_q[idx];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rd_sum_o[a] = sum_q[idx][a];
      rd_min_o[a] = min_q[rd_off_i][a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      for (int b = 0; b < MAX_BLOCKS; b++) begin
        cnt_q[b] <= '0;
        for (int a = 0; a < 3; a++) begin
          sum_q[b][a] <= '0;
          min_q[b][a] <= '0;
        end
      end
    end else begin
      if (push_o) begin
        busy_q <= 1'b1;
      end else if (clr_i) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        for (int a = 0; a < 3; a++) begin
          min_q[blk_i[OFF_W-1:0]][a] <= pos_i[a];
        end
      end
      if (clear_all) begin
        for (int b = 0; b < MAX_BLOCKS; b++) begin
          cnt_q[b] <= '0;
          for (int a = 0; a < 3; a++) begin
            sum_q[b][a] <= '0;
          end
        end
      end else if (add_ok) begin
        cnt_q[idx] <= cnt_q[idx] + 1'b1;
        for (int a = 0; a < 3; a++) begin
          sum_q[idx][a] <= sum_q[idx][a] + SUM_W'(pos_i[a]);
        end
      end
    end
  end

endmodule

// ----- sv/bchr_back.sv -----
// ----------------------------------------------------------------------------
// bchr_back
// per block: center of mass, minimum image and spring force, one axis at a time
// ----------------------------------------------------------------------------
module bchr_back
  import bchr_pkg::*;
#(
  parameter int unsigned OFF_W     = 3,
  parameter int unsigned NACT_W    = 4,
  parameter int unsigned CNT_W     = 17,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tok_valid_i,
  input  logic [NACT_W-1:0]       tok_nact_i,
  output logic                    tok_pop_o,
  output logic [OFF_W-1:0]        rd_off_o,
  input  logic [CNT_W-1:0]        rd_cnt_i,
  input  logic signed [SUM_W-1:0] rd_sum_i [3],
  input  logic signed [POS_W-1:0] rd_min_i [3],
  input  logic [K_W-1:0]          k_i,
  input  logic [BOX_W-1:0]        box_i [3],
  output logic                    clr_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [OUT_OFF_W-1:0]    off_o,
  output logic signed [POS_W-1:0] force_o [3],
  output logic                    empty_o,
  output logic                    last_o
);

  localparam int unsigned QW = MUL_W - FRAC_BITS;

  back_state_e state_q, state_d;

  logic [NACT_W-1:0]       nact_q;
  logic [OFF_W-1:0]        off_q;
  logic [1:0]              axis_q;
  logic                    neg_q, empty_q;
  logic signed [POS_W-1:0] min_q;
  logic signed [D_W-1:0]   d_q;
  logic [MUL_W-1:0]        mag_q, acc_q;
  logic [4:0]              bit_q;
  logic                    pos_q;
  logic signed [POS_W-1:0] frc_q [3];

  // output register
  logic                    ovalid_q, olast_q, oempty_q;
  logic [OUT_OFF_W-1:0]    ooff_q;
  logic signed [POS_W-1:0] ofrc_q [3];

  // shared divider
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den, div_rem;

  logic signed [SUM_W-1:0] sum_s;
  logic [SUM_W-1:0]        sum_mag;
  logic [BOX_W-1:0]        len;
  logic [D_W-1:0]          d_mag;
  logic signed [D_W-1:0]   com, d_new, dimg, dimg_mag;
  logic signed [33:0]      rs, rs_half;
  logic [QW-1:0]           q;
  logic signed [POS_W-1:0] frc_new;
  logic                    is_last, slot_free;

  bchr_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  assign rd_off_o  = off_q;
  assign sum_s     = rd_sum_i[axis_q];
  assign sum_mag   = sum_s[SUM_W-1] ? -sum_s : sum_s;
  assign len       = box_i[axis_q];
  assign d_mag     = d_q[D_W-1] ? -d_q : d_q;
  assign is_last   = (NACT_W'(off_q) + 1'b1) == nact_q;
  assign slot_free = !ovalid_q || ready_i;

  // mean: magnitude rounded half away from zero, then signed
  assign com   = neg_q ? -D_W'(div_quot[SUM_W:0]) : D_W'(div_quot[SUM_W:0]);
  assign d_new = com - D_W'(min_q);

  // minimum image from remainder of (2|d| + L - 1) / 2L
  assign rs       = $signed({1'b0, div_rem}) + 34'sd1 - $signed({3'b0, len});
  assign rs_half  = rs >>> 1;
  assign dimg     = d_q[D_W-1] ? -D_W'(rs_half) : D_W'(rs_half);
  assign dimg_mag = dimg[D_W-1] ? -dimg : dimg;

  // round product half away from zero and saturate
  assign q = acc_q[MUL_W-1:FRAC_BITS] + QW'(acc_q[FRAC_BITS-1]);
  always_comb begin
    if (pos_q) begin
      if ((|q[QW-1:32]) || (q[31] && (|q[30:0]))) begin
        frc_new = POS_W'(33'h0_8000_0000);
      end else begin
        frc_new = -$signed(q[31:0]);
      end
    end else begin
      if (|q[QW-1:31]) begin
        frc_new = POS_W'(33'h0_7FFF_FFFF);
      end else begin
        frc_new = $signed(q[31:0]);
      end
    end
  end

  always_comb begin
    div_num = '0;
    div_den = '0;
    if (state_q == B_LOAD) begin
      div_num = DIV_NUM_W'(sum_mag) + DIV_NUM_W'(rd_cnt_i >> 1);
      div_den = DIV_DEN_W'(rd_cnt_i);
    end else begin
      div_num = {d_mag[D_W-2:0], 1'b0} + DIV_NUM_W'(len) - 1'b1;
      div_den = DIV_DEN_W'({len, 1'b0});
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (tok_valid_i) state_d = B_LOAD;
      B_LOAD:  state_d = (rd_cnt_i == '0) ? B_OUT : B_DIV1;
      B_DIV1:  if (div_done) state_d = B_DIFF;
      B_DIFF:  state_d = (len == '0) ? B_MUL : B_DIV2;
      B_DIV2:  if (div_done) state_d = B_MUL;
      B_MUL:   if (bit_q == 5'd31) state_d = B_SAT;
      B_SAT:   state_d = (axis_q == 2'd2) ? B_OUT : B_LOAD;
      B_OUT:   if (slot_free) state_d = is_last ? B_CLEAR : B_LOAD;
      B_CLEAR: state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    tok_pop_o = 1'b0;
    div_start = 1'b0;
    clr_o     = 1'b0;
    case (state_q)
      B_IDLE:  tok_pop_o = tok_valid_i;
      B_LOAD:  div_start = rd_cnt_i != '0;
      B_DIFF:  div_start = len != '0;
      B_CLEAR: clr_o     = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_OUT && slot_free) begin
        ovalid_q <= 1'b1;
      end else if (ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        nact_q <= tok_nact_i;
        off_q  <= '0;
        axis_q <= '0;
      end
      B_LOAD: begin
        neg_q   <= sum_s[SUM_W-1];
        min_q   <= rd_min_i[axis_q];
        empty_q <= rd_cnt_i == '0;
        if (rd_cnt_i == '0) begin
          for (int a = 0; a < 3; a++) begin
            frc_q[a] <= '0;
          end
        end
      end
      B_DIV1: if (div_done) d_q <= d_new;
      B_DIFF: begin
        acc_q <= '0;
        bit_q <= '0;
        mag_q <= MUL_W'(d_mag);
        pos_q <= !d_q[D_W-1] && (d_q != '0);
      end
      B_DIV2: begin
        acc_q <= '0;
        bit_q <= '0;
        if (div_done) begin
          mag_q <= MUL_W'(dimg_mag);
          pos_q <= !dimg[D_W-1] && (dimg != '0);
        end
      end
      B_MUL: begin
        if (k_i[bit_q]) acc_q <= acc_q + mag_q;
        mag_q <= mag_q << 1;
        bit_q <= bit_q + 1'b1;
      end
      B_SAT: begin
        frc_q[axis_q] <= frc_new;
        axis_q        <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
      end
      B_OUT: begin
        if (slot_free) begin
          ooff_q   <= OUT_OFF_W'(off_q);
          oempty_q <= empty_q;
          olast_q  <= is_last;
          for (int a = 0; a < 3; a++) begin
            ofrc_q[a] <= frc_q[a];
          end
          off_q  <= off_q + 1'b1;
          axis_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign valid_o = ovalid_q;
  assign off_o   = ooff_q;
  assign empty_o = oempty_q;
  assign last_o  = olast_q;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      force_o[a] = ofrc_q[a];
    end
  end

endmodule

// ----- verif/tb_block_com_harmonic_restraint.sv -----
// ----------------------------------------------------------------------------
// tb_block_com_harmonic_restraint
// self-checking bench: directed table then random frames against a predictor
// ----------------------------------------------------------------------------
module tb_block_com_harmonic_restraint;
  import bchr_pkg::*;

  localparam int unsigned NBLK      = 8;
  localparam int unsigned BEAD_CAP  = 65536;
  localparam int unsigned FRAC      = 16;
  localparam int unsigned CYC_LIMIT = 3000000;

  // one input request
  typedef struct {
    op_e         op;
    logic [7:0]  blk;
    logic [31:0] px, py, pz;
    logic        lst;
  } bead_t;

  // one block force result
  typedef struct {
    logic [2:0]  off;
    logic [31:0] fx, fy, fz;
    logic        empty;
    logic        lst;
  } force_t;

  // directed row: request plus optional typed-in expectations
  typedef struct {
    bead_t  req;
    bit     typed;
    force_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DAT_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DAT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  block_com_harmonic_restraint dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]         win_start;
  logic [3:0]         win_count;
  logic [31:0]        k_spring;
  logic [30:0]        box_len [3];
  logic signed [31:0] min_pos [NBLK][3];
  logic signed [47:0] pos_sum [NBLK][3];
  int unsigned        bead_cnt [NBLK];

  force_t expected_forces[$];
  int     errors;
  int     send_idle_pct, recv_idle_pct;
  bit     hold_recv;
  longint cycles;

  // rounded mean, ties away from zero
  function automatic longint com_of(logic signed [47:0] s, int unsigned n);
    longint v, q;
    v = s;
    q = ((v < 0 ? -v : v) + n / 2) / n;
    return v < 0 ? -q : q;
  endfunction

  function automatic longint wrap_axis(longint d, longint l);
    longint m;
    if (l == 0) return d;
    if (2 * d > l) begin
      m = (2 * d - l + 2 * l - 1) / (2 * l);
      return d - m * l;
    end
    if (-2 * d > l) begin
      m = (-2 * d - l + 2 * l - 1) / (2 * l);
      return d + m * l;
    end
    return d;
  endfunction

  // -k*d, rounded and saturated; 128-bit product avoids overflow
  function automatic logic [31:0] spring_of(longint d);
    logic [127:0] p, q;
    logic [63:0]  mag;
    mag = d < 0 ? -d : d;
    p = mag * k_spring;
    q = p >> FRAC;
    if (p[FRAC-1]) q = q + 1;
    if (d > 0) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic predict_bead(bead_t b);
    int unsigned nact, o;
    force_t f;
    longint d;
    nact = win_count > NBLK ? NBLK : win_count;
    if (b.op == OP_LOAD_MIN) begin
      if (b.blk < NBLK) begin
        min_pos[b.blk][0] = b.px;
        min_pos[b.blk][1] = b.py;
        min_pos[b.blk][2] = b.pz;
      end
      return;
    end
    if (b.blk >= win_start && b.blk - win_start < nact) begin
      o = b.blk - win_start;
      if (bead_cnt[o] < BEAD_CAP) begin
        bead_cnt[o]++;
        pos_sum[o][0] += $signed(b.px);
        pos_sum[o][1] += $signed(b.py);
        pos_sum[o][2] += $signed(b.pz);
      end
    end
    if (!b.lst) return;
    for (int i = 0; i < nact; i++) begin
      f.off = i[2:0];
      f.lst = (i == nact - 1);
      f.empty = (bead_cnt[i] == 0);
      f.fx = '0; f.fy = '0; f.fz = '0;
      if (!f.empty) begin
        for (int a = 0; a < 3; a++) begin
          d = wrap_axis(com_of(pos_sum[i][a], bead_cnt[i]) - longint'(min_pos[i][a]),
                        longint'(box_len[a]));
          if (a == 0) f.fx = spring_of(d);
          else if (a == 1) f.fy = spring_of(d);
          else f.fz = spring_of(d);
        end
      end
      expected_forces.push_back(f);
    end
    for (int i = 0; i < NBLK; i++) begin
      bead_cnt[i] = 0;
      for (int a = 0; a < 3; a++) pos_sum[i][a] = '0;
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START_BLOCK: win_start = val[7:0];
      CFG_ACTIVE:      win_count = val[3:0];
      CFG_SPRING:      k_spring = val;
      CFG_BOX_X:       box_len[0] = val[30:0];
      CFG_BOX_Y:       box_len[1] = val[30:0];
      default:         box_len[2] = val[30:0];
    endcase
  endtask

  // offer one request at the falling edge, keep valid high until taken;
  // valid stays high afterwards so the next request can follow at once
  task automatic send_bead(bead_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.op;
    s_axis_tlast  <= b.lst;
    s_axis_tdata  <= {b.pz, b.py, b.px, b.blk};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_bead(b);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (expected_forces.size() != 0) @(negedge clk_i);
  endtask

  // idle: all results in, then the back end's worst-case tail
  task automatic drain_all();
    wait_results();
    repeat (4000) @(negedge clk_i);
  endtask

  function automatic bead_t rand_bead(bit lst_ok);
    bead_t b;
    int c;
    b.op  = ($urandom_range(19) == 0) ? OP_LOAD_MIN : OP_BEAD;
    c = $urandom_range(9);
    // mostly beads inside the window, some outside, some full-range indices
    if (c < 7) b.blk = win_start + $urandom_range(win_count > 0 ? win_count - 1 : 0);
    else if (c < 9) b.blk = $urandom_range(NBLK - 1);
    else b.blk = $urandom;
    c = $urandom_range(3);
    b.px = c == 0 ? $urandom : $signed($urandom_range(2000000)) - 1000000;
    b.py = c == 0 ? $urandom : $signed($urandom_range(2000000)) - 1000000;
    b.pz = c == 0 ? $urandom : $signed($urandom_range(2000000)) - 1000000;
    b.lst = lst_ok && ($urandom_range(7) == 0);
    return b;
  endfunction

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_recv) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    force_t got, w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.off = m_axis_tdata[2:0];
      got.fx  = m_axis_tdata[34:3];
      got.fy  = m_axis_tdata[66:35];
      got.fz  = m_axis_tdata[98:67];
      got.empty = m_axis_tuser;
      got.lst = m_axis_tlast;
      if (expected_forces.size() == 0) begin
        $error("unexpected result offset %0d", got.off);
        errors++;
      end else begin
        w = expected_forces.pop_front();
        if (got.off !== w.off) begin
          $error("block_offset exp %0d got %0d", w.off, got.off); errors++;
        end
        if (got.fx !== w.fx) begin
          $error("force_x exp %h got %h", w.fx, got.fx); errors++;
        end
        if (got.fy !== w.fy) begin
          $error("force_y exp %h got %h", w.fy, got.fy); errors++;
        end
        if (got.fz !== w.fz) begin
          $error("force_z exp %h got %h", w.fz, got.fz); errors++;
        end
        if (got.empty !== w.empty) begin
          $error("empty_block exp %0d got %0d", w.empty, got.empty); errors++;
        end
        if (got.lst !== w.lst) begin
          $error("last exp %0d got %0d", w.lst, got.lst); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  row_t table_rows[$];

  function automatic row_t mk(op_e op, logic [7:0] blk, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic lst);
    row_t r;
    r.req = '{op, blk, x, y, z, lst};
    r.typed = 1'b0;
    r.want = '{3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0};
    return r;
  endfunction

  initial begin
    row_t r;
    int n_rand, lim;
    errors = 0; cycles = 0; hold_recv = 1'b0;
    send_idle_pct = 7; recv_idle_pct = 58;
    win_start = 0; win_count = 1; k_spring = 0;
    for (int a = 0; a < 3; a++) box_len[a] = 31'd65536;
    for (int i = 0; i < NBLK; i++) begin
      bead_cnt[i] = 0;
      for (int a = 0; a < 3; a++) begin
        min_pos[i][a] = '0; pos_sum[i][a] = '0;
      end
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // after reset: empty frame on the default window gives an empty flag
    r = mk(OP_BEAD, 8'd5, 32'h1, 32'h1, 32'h1, 1'b1);
    r.typed = 1'b1;
    r.want = '{3'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1};
    table_rows.push_back(r);
    // k is zero after reset: a bead still gives zero force, not empty
    r = mk(OP_BEAD, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    r.typed = 1'b1;
    r.want = '{3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1};
    table_rows.push_back(r);
    foreach (table_rows[i]) begin
      send_bead(table_rows[i].req);
      if (table_rows[i].typed) begin
        // typed-in result stands in for the predicted one
        if (expected_forces.size() != 0)
          expected_forces[expected_forces.size() - 1] = table_rows[i].want;
        wait_results();
      end
    end
    drain_all();

    // full window, max k, a zero, a maximal and a unit box
    write_reg(CFG_ACTIVE, 32'd15);          // above the table size, acts as eight
    write_reg(CFG_SPRING, 32'hFFFF_FFFF);
    write_reg(CFG_BOX_X, 32'd0);
    write_reg(CFG_BOX_Y, 32'h7FFF_FFFF);
    write_reg(CFG_BOX_Z, 32'd1);
    table_rows.delete();
    table_rows.push_back(mk(OP_LOAD_MIN, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b1));
    table_rows.push_back(mk(OP_LOAD_MIN, 8'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5, 1'b0));
    table_rows.push_back(mk(OP_LOAD_MIN, 8'd200, 32'h1234, 32'h1234, 32'h1234, 1'b0));
    table_rows.push_back(mk(OP_BEAD, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h3, 1'b0));
    table_rows.push_back(mk(OP_BEAD, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4, 1'b0));
    table_rows.push_back(mk(OP_BEAD, 8'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    table_rows.push_back(mk(OP_BEAD, 8'd3, 32'hFFFF_FFFF, 32'h1, 32'h0, 1'b0));
    table_rows.push_back(mk(OP_BEAD, 8'd3, 32'h0, 32'h0, 32'h1, 1'b0));
    // last bead outside the window still ends the frame
    table_rows.push_back(mk(OP_BEAD, 8'd255, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1, 1'b1));
    foreach (table_rows[i]) send_bead(table_rows[i].req);
    drain_all();

    // zero active blocks: last emits nothing
    write_reg(CFG_ACTIVE, 32'd0);
    write_reg(CFG_START_BLOCK, 32'd255);
    r = mk(OP_BEAD, 8'd255, 32'h1, 32'h2, 32'h3, 1'b1);
    send_bead(r.req);
    drain_all();

    // random phases with differing settings and idling patterns
    n_rand = 0;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 58; recv_idle_pct = 7; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(CFG_START_BLOCK, ph == 2 ? 32'd250 : $urandom_range(4));
      write_reg(CFG_ACTIVE, $urandom_range(1, 8));
      write_reg(CFG_SPRING, ph == 1 ? 32'd0 : $urandom);
      write_reg(CFG_BOX_X, $urandom_range(1, 3000000));
      write_reg(CFG_BOX_Y, $urandom >> 1);
      write_reg(CFG_BOX_Z, ph == 0 ? 32'd0 : $urandom_range(1, 400000));
      lim = 75;
      for (int i = 0; i < lim; i++) begin
        bead_t b;
        b = rand_bead(1'b1);
        if (i == lim - 1) begin b.op = OP_BEAD; b.lst = 1'b1; end
        // long receiver hold-off on a last bead while beads keep coming
        if (ph == 0 && i == 30) begin
          b.op = OP_BEAD;
          b.lst = 1'b1;
          hold_recv = 1'b1;
          fork
            begin repeat (3000) @(negedge clk_i); hold_recv = 1'b0; end
          join_none
        end
        // sender pause until every result has come
        if (ph == 1 && i == 40)
          wait_results();
        send_bead(b);
        n_rand++;
      end
      drain_all();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
